// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DPR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dpr assertion failed");

// Check that a condition implies another one in the next cycle.
`define DPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpr assertion failed");

`endif

// ===== src/dpr_pkg.sv =====
package dpr_pkg;

  localparam int VecLen     = 8;
  localparam int IdxW       = (VecLen > 1) ? $clog2(VecLen) : 1;
  localparam int ElemW      = 8;
  localparam int DataW      = 32;
  localparam int OffW       = 8;
  localparam int ProdW      = 2 * ElemW;

  localparam int SlotShift  = 3;
  localparam int SlotBytes  = 1 << SlotShift;
  localparam int VecBase    = 'h10;
  localparam int VecEnd     = VecBase + 2 * VecLen * SlotBytes;
  localparam int ResultAddr = VecEnd;
  localparam int BusyAddr   = VecEnd + 2 * SlotBytes;
  localparam int CtrlAddr   = 'h00;
  localparam int SlotW      = OffW - SlotShift;

  localparam int CtrlStartBit = 0;
  localparam int CtrlDoneBit  = 1;
  localparam int CtrlIdleBit  = 2;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_CTRL_READ,
    CMD_VEC_WRITE,
    CMD_VEC_READ,
    CMD_RESULT_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  second;
    logic [IdxW-1:0]       idx;
    logic [ElemW-1:0]      data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/dpr_queue.sv =====
module dpr_queue import dpr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_cmd_i,
  input  logic      pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/dpr_front.sv =====
module dpr_front import dpr_pkg::*; (
  input  logic             start_i,
  input  logic             operation_i,
  input  logic [OffW-1:0]  offset_i,
  input  logic [DataW-1:0] write_data_i,
  input  q_status_t        q_status_i,
  output logic             busy_o,
  output logic             push_o,
  output cmd_t             push_cmd_o
);

  logic [OffW-1:0]  off_rel;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] idx_full;
  logic             is_vec;
  logic             second;

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  always_comb begin
    off_rel  = offset_i - OffW'(VecBase);
    slot     = off_rel[OffW-1:SlotShift];
    second   = (int'(slot) >= VecLen);
    idx_full = second ? slot - SlotW'(VecLen) : slot;
    is_vec   = (int'(offset_i) >= VecBase) && (int'(offset_i) < VecEnd) &&
               (off_rel[SlotShift-1:0] == '0);

    push_cmd_o.kind   = CMD_NONE;
    push_cmd_o.second = second;
    push_cmd_o.idx    = idx_full[IdxW-1:0];
    push_cmd_o.data   = write_data_i[ElemW-1:0];

    // Classify the request; anything unmapped or read-only on write answers zero.
    priority if (int'(offset_i) == CtrlAddr) begin
      if (!operation_i) begin
        push_cmd_o.kind = CMD_CTRL_READ;
      end else if (write_data_i[CtrlStartBit]) begin
        push_cmd_o.kind = CMD_START;
      end
    end else if (is_vec) begin
      push_cmd_o.kind = operation_i ? CMD_VEC_WRITE : CMD_VEC_READ;
    end else if (int'(offset_i) == ResultAddr) begin
      if (!operation_i) begin
        push_cmd_o.kind = CMD_RESULT_READ;
      end
    end else begin
      push_cmd_o.kind = CMD_NONE;
    end
  end

endmodule

// ===== src/dpr_back.sv =====
module dpr_back import dpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_status_i,
  input  cmd_t             head_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [DataW-1:0] read_data_o
);

  typedef enum logic {ST_IDLE, ST_MAC} state_e;

  state_e            state_q;
  logic [ElemW-1:0]  vec_a_q [VecLen];
  logic [ElemW-1:0]  vec_b_q [VecLen];
  logic [DataW-1:0]  sum_q, acc_q, acc_d;
  logic              done_q;
  logic [IdxW-1:0]   k_q;
  logic              result_valid_q;
  logic [DataW-1:0]  read_data_q;

  logic [IdxW-1:0]   rd_idx;
  logic [ElemW-1:0]  elem_a, elem_b, elem_sel;
  logic signed [ProdW-1:0] prod;
  logic [DataW-1:0]  ctrl_word;

  assign pop_o          = (state_q == ST_IDLE) && !q_status_i.empty;
  assign result_valid_o = result_valid_q;
  assign read_data_o    = read_data_q;

  always_comb begin
    rd_idx   = (state_q == ST_MAC) ? k_q : head_i.idx;
    elem_a   = vec_a_q[rd_idx];
    elem_b   = vec_b_q[rd_idx];
    elem_sel = head_i.second ? elem_b : elem_a;
    prod     = $signed(elem_a) * $signed(elem_b);
    acc_d    = acc_q + {{(DataW - ProdW){prod[ProdW-1]}}, prod};
    ctrl_word              = '0;
    ctrl_word[CtrlIdleBit] = 1'b1;
    ctrl_word[CtrlDoneBit] = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sum_q          <= '0;
      acc_q          <= '0;
      done_q         <= 1'b0;
      k_q            <= '0;
      result_valid_q <= 1'b0;
      read_data_q    <= '0;
      for (int i = 0; i < VecLen; i++) begin
        vec_a_q[i] <= '0;
        vec_b_q[i] <= '0;
      end
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            read_data_q <= '0;
            unique case (head_i.kind)
              CMD_START: begin
                acc_q   <= '0;
                k_q     <= '0;
                state_q <= ST_MAC;
              end
              CMD_CTRL_READ: begin
                result_valid_q <= 1'b1;
                read_data_q    <= ctrl_word;
                done_q         <= 1'b0;
              end
              CMD_VEC_WRITE: begin
                result_valid_q <= 1'b1;
                if (head_i.second) begin
                  vec_b_q[head_i.idx] <= head_i.data;
                end else begin
                  vec_a_q[head_i.idx] <= head_i.data;
                end
              end
              CMD_VEC_READ: begin
                result_valid_q <= 1'b1;
                read_data_q    <= {{(DataW - ElemW){1'b0}}, elem_sel};
              end
              CMD_RESULT_READ: begin
                result_valid_q <= 1'b1;
                read_data_q    <= sum_q;
              end
              default: begin
                result_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_MAC: begin
          acc_q <= acc_d;
          k_q   <= k_q + 1'b1;
          if (k_q == IdxW'(VecLen - 1)) begin
            sum_q          <= acc_d;
            done_q         <= 1'b1;
            result_valid_q <= 1'b1;
            read_data_q    <= '0;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/dot_product_register_device.sv =====
// Register-mapped dot product of two signed 8-bit vectors.
//
// Request channel: drive operation_i (0 read, 1 write), offset_i and
// write_data_i with start_i high; the request is taken at a rising edge
// where busy_o is low. Map: control 0x00, first vector 0x10..0x48, second
// vector 0x50..0x88 (8-byte slots), result 0x90, busy 0xA0 (reads as zero).
// Result channel: every request returns exactly one read_data_o word,
// shown for one cycle with result_valid_o high, in request order. Writes
// and unmapped offsets return zero. The receiver cannot stall the block.
// A plain access is taken into a two-entry queue and executed by the
// back end once it is idle; its response is registered there.
// A control write with bit 0 set runs one signed 8x8 multiply-accumulate
// per element, over VecLen elements (8 by default) in the back end; its
// response is zero and done is set.
// Throughput: one plain access per cycle; busy_o rises only when the
// queue is full, which happens while a sum is being formed.
// Reset clears vectors, result, done and the queue; no result is pending.
module dot_product_register_device import dpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             operation_i,
  input  logic [OffW-1:0]  offset_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             result_valid_o,
  output logic [DataW-1:0] read_data_o
);

  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_status;

  // Decode each request and push it.
  dpr_front u_front (
    .start_i      (start_i),
    .operation_i  (operation_i),
    .offset_i     (offset_i),
    .write_data_i (write_data_i),
    .q_status_i   (q_status),
    .busy_o       (busy_o),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  // Hold decoded requests while the back end works on a sum.
  dpr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Execute requests in order against the register file and the MAC.
  dpr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o)
  );

endmodule

// ===== src/dpr_checker.sv =====
`include "assert_macros.svh"

module dpr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o
);

  logic       accept;
  logic [2:0] pending_q, pending_d;

  assign accept = start_i && !busy_o;

  // Track requests taken but not yet answered.
  always_comb begin
    pending_d = pending_q;
    if (accept && !result_valid_o) begin
      pending_d = pending_q + 1'b1;
    end else if (result_valid_o && !accept) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `DPR_ASSERT(a_no_spurious_result, clk_i, rst_ni, result_valid_o |-> (pending_q != 3'd0))
  `DPR_ASSERT(a_pending_bounded, clk_i, rst_ni, pending_q <= 3'd4)
  `DPR_ASSERT(a_idle_not_busy, clk_i, rst_ni, (pending_q == 3'd0) |-> !busy_o)
  `DPR_ASSERT_NEXT(a_lone_access_answers, clk_i, rst_ni, (pending_q == 3'd0) && accept, !result_valid_o)

endmodule

bind dot_product_register_device dpr_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o)
);

// ===== bench/dot_product_register_device_test.sv =====
`timescale 1ns / 1ps

module dot_product_register_device_test;
  import dpr_pkg::*;

  // Bus access kinds on operation_i.
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam int RandomRequests = 1400;
  localparam int MaxReports     = 10;
  // A start runs one multiply-accumulate per element before its response.
  localparam int TailCycles     = 4 * VecLen + 16;
  localparam int CycleLimit     = 600000;

  typedef struct {
    logic             op;
    logic [OffW-1:0]  offset;
    logic [DataW-1:0] data;
    int               gap;    // idle cycles before this request
    bit               drain;  // hold the bus until every response is back
  } bus_req_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             operation_i = OpRead;
  logic [OffW-1:0]  offset_i = '0;
  logic [DataW-1:0] write_data_i = '0;
  logic             busy_o;
  logic             result_valid_o;
  logic [DataW-1:0] read_data_o;

  bus_req_t         pending_requests[$];
  logic [DataW-1:0] expected_reads[$];
  int               fail_count = 0;
  int               cycle_count = 0;
  int               requests_planned = 0;
  bit               quiet_stretch = 1'b0;

  // Shadow copy of the register file.
  logic [ElemW-1:0] first_vec [VecLen] = '{default: '0};
  logic [ElemW-1:0] second_vec[VecLen] = '{default: '0};
  logic [DataW-1:0] sum_shadow = '0;
  bit               done_shadow = 1'b0;

  dot_product_register_device dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .offset_i      (offset_i),
    .write_data_i  (write_data_i),
    .result_valid_o(result_valid_o),
    .read_data_o   (read_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Signed sum of element products, wrapped to 32 bits.
  function automatic logic [DataW-1:0] dot_of_vectors();
    logic signed [DataW-1:0] acc;
    acc = '0;
    for (int k = 0; k < VecLen; k++) begin
      acc += $signed(first_vec[k]) * $signed(second_vec[k]);
    end
    return acc;
  endfunction

  // Apply one bus access to the shadow registers and return the response word.
  function automatic logic [DataW-1:0] apply_bus_access(logic op, logic [OffW-1:0] off,
                                                        logic [DataW-1:0] data);
    logic [DataW-1:0] word;
    int               slot;
    word = '0;
    if (int'(off) == CtrlAddr) begin
      if (op == OpWrite) begin
        if (data[CtrlStartBit]) begin
          sum_shadow  = dot_of_vectors();
          done_shadow = 1'b1;
        end
      end else begin
        word[CtrlIdleBit] = 1'b1;
        word[CtrlDoneBit] = done_shadow;
        done_shadow       = 1'b0;  // reading control clears done
      end
    end else if (int'(off) >= VecBase && int'(off) < VecEnd &&
                 off[SlotShift-1:0] == '0) begin
      slot = (int'(off) - VecBase) >> SlotShift;
      if (op == OpWrite) begin
        if (slot < VecLen) first_vec[slot] = data[ElemW-1:0];
        else               second_vec[slot - VecLen] = data[ElemW-1:0];
      end else begin
        word = (slot < VecLen) ? DataW'(first_vec[slot]) : DataW'(second_vec[slot - VecLen]);
      end
    end else if (int'(off) == ResultAddr && op == OpRead) begin
      word = sum_shadow;
    end
    // Busy reads as zero; unmapped and misaligned offsets fall through to zero.
    return word;
  endfunction

  // Most gaps are short, a few long; quiet stretches run back to back.
  function automatic int pick_gap();
    int r;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_request(logic op, int off, logic [DataW-1:0] data);
    bus_req_t req;
    req.op     = op;
    req.offset = OffW'(off);
    req.data   = data;
    req.gap    = pick_gap();
    req.drain  = 1'b0;
    pending_requests.push_back(req);
    requests_planned++;
  endfunction

  function automatic void queue_pause();
    bus_req_t req;
    req.op     = OpRead;
    req.offset = '0;
    req.data   = '0;
    req.gap    = 0;
    req.drain  = 1'b1;
    pending_requests.push_back(req);
  endfunction

  function automatic int vec_offset(int slot);
    return VecBase + SlotBytes * slot;
  endfunction

  // Element write word: extremes often, junk in the upper bits always.
  function automatic logic [DataW-1:0] element_word();
    logic [DataW-1:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[ElemW-1:0] = 8'h80;
      1: w[ElemW-1:0] = 8'h7F;
      2: w[ElemW-1:0] = 8'hFF;
      3: w[ElemW-1:0] = 8'h00;
      4: w[ElemW-1:0] = 8'h01;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [DataW-1:0] control_word(bit go);
    logic [DataW-1:0] w;
    w = $urandom();
    w[CtrlStartBit] = go;
    return w;
  endfunction

  // Request driver: a request moves when start_i is high and busy_o is low.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    bit       taken;
    bit       issue;
    bit       gap_served;
    int       gap_left;
    bus_req_t head;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      operation_i  <= OpRead;
      offset_i     <= '0;
      write_data_i <= '0;
      gap_left     = 0;
      gap_served   = 1'b0;
    end else begin
      taken = start_i && !busy_o;
      issue = 1'b0;
      if (taken) begin
        expected_reads.push_back(apply_bus_access(operation_i, offset_i, write_data_i));
      end
      // A held request stays on the bus until it is taken.
      if (!start_i || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          if (pending_requests[0].drain) begin
            if (expected_reads.size() == 0) void'(pending_requests.pop_front());
          end else if (!gap_served && pending_requests[0].gap > 0) begin
            gap_left   = pending_requests[0].gap - 1;
            gap_served = 1'b1;
          end else begin
            head       = pending_requests.pop_front();
            gap_served = 1'b0;
            issue      = 1'b1;
          end
        end
      end
      if (issue) begin
        start_i      <= 1'b1;
        operation_i  <= head.op;
        offset_i     <= head.offset;
        write_data_i <= head.data;
      end else if (taken) begin
        start_i <= 1'b0;
      end
    end
  end

  // Response monitor: every strobe must match the oldest outstanding request.
  always @(posedge clk_i) begin : response_monitor
    logic [DataW-1:0] want;
    if (rst_ni && result_valid_o) begin
      if (expected_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected response: read_data %h", read_data_o);
      end else begin
        want = expected_reads.pop_front();
        if (read_data_o !== want) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("read_data mismatch: expected %h, got %h", want, read_data_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int scenario;
    int count;
    int slot;
    bit full_load;

    // Directed: reset values, element extremes, start corner cases,
    // read-only registers and misaligned offsets.
    quiet_stretch = 1'b1;
    queue_request(OpRead,  CtrlAddr,           32'hFFFF_FFFF);
    queue_request(OpRead,  ResultAddr,         32'h0);
    queue_request(OpRead,  BusyAddr,           32'h0);
    queue_request(OpRead,  vec_offset(0),      32'h0);
    queue_request(OpWrite, vec_offset(0),      32'hFFFF_FF80);
    queue_request(OpWrite, vec_offset(VecLen - 1), 32'h0000_007F);
    queue_request(OpWrite, vec_offset(VecLen), 32'hABCD_EF80);
    queue_request(OpWrite, vec_offset(2 * VecLen - 1), 32'h0000_0080);
    queue_request(OpWrite, CtrlAddr,           32'hFFFF_FFFE);  // start bit clear
    queue_request(OpRead,  CtrlAddr,           32'h0);
    queue_request(OpRead,  ResultAddr,         32'h0);
    queue_request(OpWrite, CtrlAddr,           32'h0000_0001);
    queue_request(OpWrite, CtrlAddr,           32'hFFFF_FFFF);  // restart while done
    queue_request(OpRead,  CtrlAddr,           32'h0);
    queue_request(OpRead,  CtrlAddr,           32'h0);
    queue_request(OpRead,  ResultAddr,         32'h0);
    queue_request(OpWrite, ResultAddr,         32'hFFFF_FFFF);
    queue_request(OpWrite, BusyAddr,           32'hFFFF_FFFF);
    queue_request(OpRead,  ResultAddr,         32'h0);
    queue_request(OpRead,  BusyAddr,           32'h0);
    queue_request(OpWrite, 'h49,               32'hFFFF_FFFF);
    queue_request(OpRead,  'h8F,               32'h0);
    queue_request(OpRead,  'hFF,               32'h0);
    queue_request(OpRead,  vec_offset(2 * VecLen - 1), 32'h0);
    queue_request(OpRead,  'h91,               32'h0);
    queue_pause();

    // Random: mostly load-start-read sequences, some noise.
    while (requests_planned < RandomRequests + 25) begin
      quiet_stretch = ($urandom_range(0, 4) == 0);
      scenario = $urandom_range(0, 9);
      if (scenario <= 5) begin
        full_load = ($urandom_range(0, 3) == 0);
        count = full_load ? 2 * VecLen : $urandom_range(1, 2 * VecLen);
        for (int i = 0; i < count; i++) begin
          slot = full_load ? i : $urandom_range(0, 2 * VecLen - 1);
          queue_request(OpWrite, vec_offset(slot), element_word());
        end
        if ($urandom_range(0, 5) != 0) queue_request(OpWrite, CtrlAddr, control_word(1'b1));
        if ($urandom_range(0, 3) != 0) queue_request(OpRead, CtrlAddr, $urandom());
        queue_request(OpRead, ResultAddr, $urandom());
        if ($urandom_range(0, 2) == 0)
          queue_request(OpRead, vec_offset($urandom_range(0, 2 * VecLen - 1)), $urandom());
      end else if (scenario <= 7) begin
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 1) == 0)
            queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom());
          else
            queue_request(1'($urandom_range(0, 1)),
                          vec_offset($urandom_range(0, 2 * VecLen + 2)) + $urandom_range(0, 7),
                          $urandom());
        end
      end else if (scenario == 8) begin
        queue_request(OpWrite, CtrlAddr, control_word(1'b0));
        queue_request(OpRead,  CtrlAddr, $urandom());
      end else begin
        queue_pause();
        queue_request(OpRead, CtrlAddr,   $urandom());
        queue_request(OpRead, ResultAddr, $urandom());
      end
    end

    // Drain: all requests taken, all responses back, then a quiet tail.
    wait (rst_ni);
    @(posedge clk_i);
    while (pending_requests.size() != 0 || start_i) @(posedge clk_i);
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && expected_reads.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dpr_pkg.sv
src/dpr_queue.sv
src/dpr_front.sv
src/dpr_back.sv
src/dot_product_register_device.sv
src/dpr_checker.sv
bench/dot_product_register_device_test.sv
